>>> rtl/ddf_pkg.sv
// ----------------------------------------------------------------------------
// ddf_pkg
// Shared symbols, result kinds and queue entry type for the DLE/STX/ETX
// deframer.
// ----------------------------------------------------------------------------
package ddf_pkg;

    localparam logic [7:0] SYM_STX = 8'h02;
    localparam logic [7:0] SYM_ETX = 8'h03;
    localparam logic [7:0] SYM_DLE = 8'h10;
    localparam logic [7:0] ESC_STX = 8'h12;
    localparam logic [7:0] ESC_ETX = 8'h13;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 11;
    localparam int KIND_W  = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] MAX_LENGTH_RST = 11'd1024;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_CSUM = 2'd2,
        KIND_OVF  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [COUNT_W-1:0]  position;
    } result_t;

endpackage

>>> rtl/ddf_front.sv
// ----------------------------------------------------------------------------
// ddf_front
// Accepts raw link bytes, tracks frame state, undoes DLE stuffing and
// classifies each byte into a queue request.
// ----------------------------------------------------------------------------
module ddf_front
    import ddf_pkg::*;
#(
    parameter int MAX_FRAME = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    input  logic                accept,
    input  logic [BYTE_W-1:0]   rx_byte,
    output logic                push,
    output result_t             push_item
);

    logic [COUNT_W-1:0] max_length_reg;
    logic               in_frame_reg, in_frame_next;
    logic               esc_reg, esc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0]  prev_reg, prev_next;
    logic               over_limit;
    logic [BYTE_W-1:0]  decoded;
    logic [BYTE_W-1:0]  body_sum;

    always_comb
    begin
        over_limit = (count_reg >= max_length_reg)
                  || ({21'd0, count_reg} >= 32'(MAX_FRAME));
        body_sum = sum_reg - prev_reg;
        decoded = rx_byte;
        if (esc_reg)
        begin
            if (rx_byte == ESC_STX)
                decoded = SYM_STX;
            else if (rx_byte == ESC_ETX)
                decoded = SYM_ETX;
        end
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        prev_next     = prev_reg;
        push          = 1'b0;
        push_item     = '{kind: KIND_DATA, data_byte: '0, position: count_reg};
        if (accept)
        begin
            if (rx_byte == SYM_STX)
            begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                count_next    = '0;
                sum_next      = '0;
                prev_next     = '0;
            end
            else if (in_frame_reg)
            begin
                if (rx_byte == SYM_ETX)
                begin
                    push           = 1'b1;
                    push_item.kind = ((count_reg != '0) && (body_sum == prev_reg))
                                     ? KIND_OK : KIND_CSUM;
                    in_frame_next  = 1'b0;
                    esc_next       = 1'b0;
                end
                else if ((rx_byte == SYM_DLE) && !esc_reg)
                begin
                    esc_next = 1'b1;
                end
                else if (over_limit)
                begin
                    push           = 1'b1;
                    push_item.kind = KIND_OVF;
                    in_frame_next  = 1'b0;
                    esc_next       = 1'b0;
                end
                else
                begin
                    push                = 1'b1;
                    push_item.data_byte = decoded;
                    esc_next            = 1'b0;
                    count_next          = count_reg + 1'b1;
                    sum_next            = sum_reg + decoded;
                    prev_next           = decoded;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
            in_frame_reg   <= 1'b0;
            esc_reg        <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            prev_reg       <= '0;
        end
        else
        begin
            if (cfg_wen)
                max_length_reg <= cfg_wdata;
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            prev_reg     <= prev_next;
        end
    end

endmodule

>>> rtl/ddf_queue.sv
// ----------------------------------------------------------------------------
// ddf_queue
// Short result queue between the classifying front and the output stage.
// ----------------------------------------------------------------------------
module ddf_queue
    import ddf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  result_t  push_item,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output result_t  head_item
);

    result_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/ddf_back.sv
// ----------------------------------------------------------------------------
// ddf_back
// Output stage: drains the result queue into a registered stream master.
// ----------------------------------------------------------------------------
module ddf_back
    import ddf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_not_empty,
    input  result_t  q_head,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_item
);

    logic     valid_reg, valid_next;
    result_t  item_reg;

    assign pop        = q_not_empty && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_item   = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= q_head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

>>> rtl/dle_stx_etx_deframer_core.sv
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer_core
// Receives DLE-stuffed STX/ETX frames one byte per cycle while the queue has
// room and emits decoded bytes, frame-ok, checksum-error and overflow results.
// ----------------------------------------------------------------------------
// Each result is stored in the result queue, then in the output register.
// Throughput: 1 byte per cycle while the result queue is not full; the
// 2-entry result queue absorbs output stalls.
// Reset: asynchronous; frame state, queue and output cleared, max_length 1024.
module dle_stx_etx_deframer_core
    import ddf_pkg::*;
#(
    parameter int MAX_FRAME = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [10:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // [7:0] data_byte, [18:8] position, zero fill
    output logic [1:0]   m_axis_tuser    // [1:0] kind
);

    logic     accept;
    logic     push;
    result_t  push_item;
    logic     q_full;
    logic     q_not_empty;
    logic     pop;
    result_t  q_head;
    result_t  out_item;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ddf_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_byte   (s_axis_tdata),
        .push      (push),
        .push_item (push_item)
    );

    ddf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_item (q_head)
    );

    ddf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_item    (out_item)
    );

    assign m_axis_tdata = {5'd0, out_item.position, out_item.data_byte};
    assign m_axis_tuser = out_item.kind;

endmodule
